// File: rtl/core/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

    // Field widths of the request and the result.
    localparam int TARGET_W = 23;
    localparam int P1_W     = 3;
    localparam int P2_W     = 5;
    localparam int P_W      = P1_W + P2_W;
    localparam int MINT_W   = 8;
    localparam int FRAC_W   = 22;
    localparam int M2_W     = MINT_W + FRAC_W;
    localparam int VCO_W    = TARGET_W + P_W;
    localparam int ERR_W    = TARGET_W + 1;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 88;

    // Default search limits.
    localparam int P1_MAX_DEF = 7;
    localparam int P2_MAX_DEF = 31;

    // Shared divider: numerator is vco << 16, divisor at most 3125.
    localparam int DIV_NUM_W = TARGET_W + 16;
    localparam int DIV_DEN_W = 12;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // 200000 kHz = 2^6 * 3125, so M2 = floor(vco * 2^16 / 3125).
    localparam logic [DIV_DEN_W-1:0] REF_DIV = 12'd3125;
    localparam int PROD_W = M2_W + DIV_DEN_W;

    // VCO window and band edges in kHz.
    localparam logic [VCO_W-1:0]    VCO_LOW_KHZ   = 31'd4800000;
    localparam logic [VCO_W-1:0]    VCO_HIGH_KHZ  = 31'd6700000;
    localparam logic [TARGET_W-1:0] BAND_HIGH_KHZ = 23'd6200000;
    localparam logic [TARGET_W-1:0] BAND_MID_KHZ  = 23'd5400000;

    // Lane stagger thresholds: symbol rate in MHz above 270, 135, 67, 33.
    localparam logic [TARGET_W-1:0] STG_T4_KHZ = 23'd271000;
    localparam logic [TARGET_W-1:0] STG_T3_KHZ = 23'd136000;
    localparam logic [TARGET_W-1:0] STG_T2_KHZ = 23'd68000;
    localparam logic [TARGET_W-1:0] STG_T1_KHZ = 23'd34000;
    localparam logic [4:0] STG_CODE_4 = 5'h18;
    localparam logic [4:0] STG_CODE_3 = 5'h0D;
    localparam logic [4:0] STG_CODE_2 = 5'h07;
    localparam logic [4:0] STG_CODE_1 = 5'h04;
    localparam logic [4:0] STG_CODE_0 = 5'h02;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_WIN,
        ST_DIV1,
        ST_VMUL,
        ST_LOAD2,
        ST_DIV2,
        ST_CMP,
        ST_FIN
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

endpackage

`default_nettype wire

// File: rtl/core/pds_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module pds_divider (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire pds_pkg::t_div_req             i_req,
    output logic [pds_pkg::DIV_NUM_W-1:0]      o_quo,
    output logic                               o_done
);
    import pds_pkg::*;

    logic [DIV_NUM_W-1:0] r_quo, n_quo;
    logic [DIV_DEN_W-1:0] r_rem, n_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;

    // One restoring step: shift in the next numerator bit and try a subtract.
    always_comb begin
        w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        if (!w_diff[DIV_DEN_W]) begin
            n_rem = w_diff[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift[DIV_DEN_W-1:0];
            n_quo = {r_quo[DIV_NUM_W-2:0], 1'b0};
        end
    end

    // Control: busy for one cycle per quotient bit, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_done <= (r_cnt == '0);
        end else begin
            r_done <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
            r_cnt <= DIV_CNT_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: rtl/core/pll_divider_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Content
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | tdata: target clock in kHz [22:0], zero pad to 24 bits
// m_axis   | out | tuser: found; tdata: post_div1, post_div2, mult_int,
//          |     |   mult_frac, frac_enable, vco_real_khz, prop_coeff,
//          |     |   gain_ctl, int_coeff, tdc_target, stagger_code
//
// Each (p1, p2) candidate is checked against the VCO window; inside it the shared
// divider runs once for M2 and, when M2 is in range, once more for the real clock.
// The result register is loaded when the search ends.
// Reset is synchronous and active low. A new request is taken while a result
// waits; the search then stalls at its end until the output register is free.

module pll_divider_search_top #(
    parameter int P1_MAX = pds_pkg::P1_MAX_DEF,
    parameter int P2_MAX = pds_pkg::P2_MAX_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire  [pds_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // target clock, pad
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // post_div1, post_div2, mult_int, mult_frac, frac_enable, vco_real_khz,
    // prop_coeff, gain_ctl, int_coeff, tdc_target, stagger_code, pad
    output logic [pds_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                o_m_axis_tuser   // found
);
    import pds_pkg::*;

    t_state r_state, n_state;

    logic [TARGET_W-1:0] r_target;
    logic [P1_W-1:0]     r_p1;
    logic [P2_W-1:0]     r_p2;
    logic [P_W-1:0]      r_p;
    logic [VCO_W-1:0]    r_vco;
    logic [M2_W-1:0]     r_m2;
    logic [TARGET_W-1:0] r_vreal;
    logic [ERR_W-1:0]    r_min_err;
    logic                r_hit;
    logic [P1_W-1:0]     r_b_p1;
    logic [P2_W-1:0]     r_b_p2;
    logic [M2_W-1:0]     r_b_m2;
    logic [TARGET_W-1:0] r_b_vco;
    logic                r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                r_out_found;

    logic                 w_in_acc;
    logic                 w_in_win;
    logic                 w_m2_ok;
    logic                 w_last;
    logic                 w_advance;
    logic                 w_better;
    logic                 w_out_load;
    t_div_req             w_div_req;
    logic [DIV_NUM_W-1:0] w_quo;
    logic                 w_div_done;
    logic [VCO_W-1:0]     w_vco_prod;
    logic [PROD_W-1:0]    w_vreal_prod;
    logic [TARGET_W-1:0]  w_dot;
    logic [TARGET_W-1:0]  w_err;
    logic [3:0]           w_prop;
    logic [2:0]           w_gain;
    logic [3:0]           w_intc;
    logic [3:0]           w_tdc;
    logic [4:0]           w_stg;
    logic [OUT_TDATA_W-1:0] w_pack;

    // Shared restoring divider.
    pds_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // Candidate arithmetic, each multiplier feeding a register.
    assign w_vco_prod   = VCO_W'(r_target) * VCO_W'(r_p);
    assign w_vreal_prod = PROD_W'(r_m2) * PROD_W'(REF_DIV);
    assign w_in_win     = (r_vco >= VCO_LOW_KHZ) && (r_vco <= VCO_HIGH_KHZ);
    assign w_m2_ok      = (w_quo[DIV_NUM_W-1:M2_W] == '0)
                       && (w_quo[M2_W-1:FRAC_W] >= MINT_W'(2));
    assign w_last       = (r_p1 == P1_W'(P1_MAX)) && (r_p2 == P2_W'(P2_MAX));
    assign w_dot        = w_quo[TARGET_W-1:0];
    assign w_err        = (w_dot > r_target) ? (w_dot - r_target) : (r_target - w_dot);
    assign w_better     = {1'b0, w_err} < r_min_err;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_MUL;
            ST_MUL:   n_state = ST_WIN;
            ST_WIN: begin
                if (w_in_win)    n_state = ST_DIV1;
                else if (w_last) n_state = ST_FIN;
                else             n_state = ST_MUL;
            end
            ST_DIV1: begin
                if (w_div_done) begin
                    if (w_m2_ok)     n_state = ST_VMUL;
                    else if (w_last) n_state = ST_FIN;
                    else             n_state = ST_MUL;
                end
            end
            ST_VMUL:  n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_DIV2;
            ST_DIV2:  if (w_div_done) n_state = ST_CMP;
            ST_CMP:   n_state = w_last ? ST_FIN : ST_MUL;
            ST_FIN:   if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_advance       = 1'b0;
        w_out_load      = 1'b0;
        w_div_req       = '0;
        case (r_state)
            ST_IDLE: o_s_axis_tready = 1'b1;
            ST_WIN: begin
                w_advance       = !w_in_win;
                w_div_req.start = w_in_win;
                w_div_req.num   = {r_vco[TARGET_W-1:0], 16'd0};
                w_div_req.den   = REF_DIV;
            end
            ST_DIV1: w_advance = w_div_done && !w_m2_ok;
            ST_LOAD2: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = DIV_NUM_W'(r_vreal);
                w_div_req.den   = DIV_DEN_W'(r_p);
            end
            ST_CMP: w_advance = 1'b1;
            ST_FIN: w_out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Search control and the best-so-far flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_hit <= 1'b0;
            end else if (r_state == ST_CMP && w_better) begin
                r_hit <= 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Candidate walk: p tracks p1 * p2 by addition.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_target   <= i_s_axis_tdata[TARGET_W-1:0];
            r_p1       <= P1_W'(1);
            r_p2       <= P2_W'(1);
            r_p        <= P_W'(1);
            r_min_err  <= '1;
        end else if (w_advance && !w_last) begin
            if (r_p2 == P2_W'(P2_MAX)) begin
                r_p1 <= r_p1 + 1'b1;
                r_p2 <= P2_W'(1);
                r_p  <= P_W'(r_p1) + P_W'(1);
            end else begin
                r_p2 <= r_p2 + 1'b1;
                r_p  <= r_p + P_W'(r_p1);
            end
        end
        if (r_state == ST_MUL) begin
            r_vco <= w_vco_prod;
        end
        if (r_state == ST_DIV1 && w_div_done) begin
            r_m2 <= w_quo[M2_W-1:0];
        end
        if (r_state == ST_VMUL) begin
            r_vreal <= w_vreal_prod[TARGET_W+15:16];
        end
        if (r_state == ST_CMP && w_better) begin
            r_min_err  <= {1'b0, w_err};
            r_b_p1     <= r_p1;
            r_b_p2     <= r_p2;
            r_b_m2     <= r_m2;
            r_b_vco    <= r_vreal;
        end
        if (w_out_load) begin
            r_out_data  <= w_pack;
            r_out_found <= r_hit;
        end
    end

    // Loop coefficients by VCO band.
    always_comb begin
        if (r_b_vco >= BAND_HIGH_KHZ) begin
            w_prop = 4'd4; w_gain = 3'd3; w_intc = 4'd9;  w_tdc = 4'd8;
        end else if (r_b_vco == BAND_MID_KHZ) begin
            w_prop = 4'd3; w_gain = 3'd1; w_intc = 4'd8;  w_tdc = 4'd9;
        end else begin
            w_prop = 4'd5; w_gain = 3'd3; w_intc = 4'd11; w_tdc = 4'd9;
        end
    end

    // Lane stagger by symbol rate, compared in kHz.
    always_comb begin
        if (r_target >= STG_T4_KHZ)      w_stg = STG_CODE_4;
        else if (r_target >= STG_T3_KHZ) w_stg = STG_CODE_3;
        else if (r_target >= STG_T2_KHZ) w_stg = STG_CODE_2;
        else if (r_target >= STG_T1_KHZ) w_stg = STG_CODE_1;
        else                             w_stg = STG_CODE_0;
    end

    // Result packing, integer part of M2 below its fraction; all zero when no
    // candidate passed.
    always_comb begin
        if (r_hit) begin
            w_pack = {6'd0, w_stg, w_tdc, w_intc, w_gain, w_prop, r_b_vco,
                      (r_b_m2[FRAC_W-1:0] != '0), r_b_m2[FRAC_W-1:0],
                      r_b_m2[M2_W-1:FRAC_W], r_b_p2, r_b_p1};
        end else begin
            w_pack = '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_found;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV1 || r_state == ST_DIV2))
        else $error("divider finished outside a divide state");

    // A recorded hit always carries a real error score.
    a_hit_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> !r_min_err[ERR_W-1])
        else $error("hit without a valid error score");

    // A missed search yields an all-zero result.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_data == '0))
        else $error("missed search with nonzero result");

    // A found result never reports a zero p1 or p2.
    a_found_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |->
            (r_out_data[P1_W-1:0] != '0 && r_out_data[P_W-1:P1_W] != '0))
        else $error("found result with zero post divider");

endmodule

`default_nettype wire
